// File: hw/rtl/lru_slot_pool_allocator_macros.svh
// ----------------------------------------------------------------------------
// lru slot pool allocator assertion macros
// shared helpers for the concurrent checks of the pool allocator
// ----------------------------------------------------------------------------
`ifndef LRU_SLOT_POOL_ALLOCATOR_MACROS_SVH
`define LRU_SLOT_POOL_ALLOCATOR_MACROS_SVH

// same-cycle implication, clocked on clk and quiet during rst
`define LSPA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk and quiet during rst
`define LSPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/lspa_pkg.sv
// ----------------------------------------------------------------------------
// lspa_pkg
// types, constants and helpers for the lru slot pool allocator
// ----------------------------------------------------------------------------
package lspa_pkg;

  localparam int NUM_SLOTS = 4;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int KEY_W     = 8;
  localparam int STAMP_W   = 16;
  localparam int IDX_W     = 2;

  localparam logic OP_TOUCH  = 1'b0;
  localparam logic OP_FORGET = 1'b1;

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [IDX_W-1:0]   idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // running search record handed from cell to cell
  typedef struct packed {
    logic   valid;
    key_t   key;
    logic   hit;
    slot_t  hit_idx;
    logic   free;
    logic   vvalid;
    slot_t  vidx;
    stamp_t vstamp;
    key_t   vkey;
  } probe_t;

  // write request from the controller to one cell
  typedef struct packed {
    logic   clear;
    logic   en;
    key_t   key;
    stamp_t stamp;
  } wr_t;

  typedef struct packed {
    idx_t slot_index;
    logic was_resident;
    logic needs_clear;
    key_t evicted_key;
  } res_t;

  // low bits of a slot index as reported on the result
  function automatic idx_t idx_out(slot_t s);
    logic [SLOT_W+IDX_W-1:0] ext;
    ext = (SLOT_W + IDX_W)'(s);
    return ext[IDX_W-1:0];
  endfunction

endpackage

// File: hw/rtl/lspa_req_if.sv
// ----------------------------------------------------------------------------
// lspa_req_if / lspa_rsp_if
// valid/ready channels carrying requests into and results out of the pool
// ----------------------------------------------------------------------------
interface lspa_req_if
  import lspa_pkg::*;
();
  logic valid;
  logic ready;
  logic opcode;
  key_t level_key;

  modport source (output valid, output opcode, output level_key, input ready);
  modport sink   (input valid, input opcode, input level_key, output ready);
endinterface

interface lspa_rsp_if
  import lspa_pkg::*;
();
  logic valid;
  logic ready;
  idx_t slot_index;
  logic was_resident;
  logic needs_clear;
  key_t evicted_key;

  modport source (output valid, output slot_index, output was_resident,
                  output needs_clear, output evicted_key, input ready);
  modport sink   (input valid, input slot_index, input was_resident,
                  input needs_clear, input evicted_key, output ready);
endinterface

// File: hw/rtl/lspa_cell.sv
// ----------------------------------------------------------------------------
// lspa_cell
// one pool slot: holds key and stamp, folds itself into the passing probe
// ----------------------------------------------------------------------------
module lspa_cell
  import lspa_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  slot_t  idx,
  input  wr_t    wr,
  input  probe_t probe_in,
  output probe_t probe_out
);

  key_t   key;
  stamp_t stamp;
  probe_t probe_next;

  always_ff @(posedge clk) begin
    if (rst || wr.clear) begin
      key   <= '0;
      stamp <= '0;
    end else if (wr.en) begin
      key   <= wr.key;
      stamp <= wr.stamp;
    end
  end

  always_comb begin
    probe_next = probe_in;
    if (!probe_in.hit && key == probe_in.key) begin
      probe_next.hit     = 1'b1;
      probe_next.hit_idx = idx;
    end
    // first free slot ends the victim search
    if (!probe_in.free) begin
      if (key == '0) begin
        probe_next.free   = 1'b1;
        probe_next.vvalid = 1'b1;
        probe_next.vidx   = idx;
        probe_next.vstamp = stamp;
        probe_next.vkey   = '0;
      end else if (!probe_in.vvalid || stamp < probe_in.vstamp) begin
        probe_next.vvalid = 1'b1;
        probe_next.vidx   = idx;
        probe_next.vstamp = stamp;
        probe_next.vkey   = key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
  end

endmodule

// File: hw/rtl/lru_slot_pool_allocator.sv
// ----------------------------------------------------------------------------
// lru_slot_pool_allocator
// fully associative slot pool with lru timestamp replacement
// ----------------------------------------------------------------------------
//  channel | dir | payload                                          | accept
//  req     | in  | opcode, level_key                                | valid & ready
//  rsp     | out | slot_index, was_resident, needs_clear, evicted_key | valid & ready
//
//  a touch that needs a search walks its probe down the chain, registered in each
//  cell, then commits in ST_SCAN and loads its result into the output register in ST_DONE
//  a forget or a repeat of the last key skips the search and goes straight to ST_DONE
//  one transaction in flight; req is ready again once its result is registered
//  rst is synchronous and empties the pool; a stalled rsp holds the result
// ----------------------------------------------------------------------------
`include "lru_slot_pool_allocator_macros.svh"

module lru_slot_pool_allocator
  import lspa_pkg::*;
(
  input logic        clk,
  input logic        rst,
  lspa_req_if.sink   req,
  lspa_rsp_if.source rsp
);

  state_t state, state_next;
  stamp_t use_clock, use_clock_next;
  slot_t  current_slot, current_slot_next;
  key_t   last_key, last_key_next;
  res_t   res, res_next;
  res_t   out_q;
  logic   out_valid;

  logic   load_out;
  logic   clear_all;
  logic   commit;
  slot_t  widx;
  probe_t head;
  probe_t chain [NUM_SLOTS];
  wr_t    wr [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] wr_en_vec;

  // only a touch that goes on to a search launches a probe
  assign head = '{valid: req.valid && req.ready && req.opcode == OP_TOUCH &&
                         req.level_key != last_key,
                  key: req.level_key, default: '0};

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    assign wr[i].clear = clear_all;
    assign wr[i].en    = commit && widx == slot_t'(i);
    assign wr[i].key   = chain[NUM_SLOTS-1].key;
    assign wr[i].stamp = use_clock_next;
    assign wr_en_vec[i] = wr[i].en;

    lspa_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (slot_t'(i)),
      .wr        (wr[i]),
      .probe_in  ((i == 0) ? head : chain[(i == 0) ? 0 : i-1]),
      .probe_out (chain[i])
    );
  end

  always_comb begin
    state_next        = state;
    res_next          = res;
    use_clock_next    = use_clock;
    current_slot_next = current_slot;
    last_key_next     = last_key;
    load_out          = 1'b0;
    clear_all         = 1'b0;
    commit            = 1'b0;
    widx              = chain[NUM_SLOTS-1].vidx;
    req.ready         = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = ST_DONE;
          if (req.opcode == OP_FORGET) begin
            clear_all         = 1'b1;
            use_clock_next    = '0;
            current_slot_next = '0;
            last_key_next     = '0;
            res_next          = '0;
          end else if (req.level_key == last_key) begin
            res_next = '{slot_index: idx_out(current_slot), was_resident: 1'b1,
                         needs_clear: 1'b0, evicted_key: '0};
          end else begin
            last_key_next = req.level_key;
            state_next    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (chain[NUM_SLOTS-1].valid) begin
          commit         = 1'b1;
          use_clock_next = use_clock + 1'b1;
          state_next     = ST_DONE;
          if (chain[NUM_SLOTS-1].hit) begin
            widx     = chain[NUM_SLOTS-1].hit_idx;
            res_next = '{slot_index: idx_out(widx), was_resident: 1'b1,
                         needs_clear: 1'b0, evicted_key: '0};
          end else begin
            res_next = '{slot_index: idx_out(widx), was_resident: 1'b0,
                         needs_clear: 1'b1, evicted_key: chain[NUM_SLOTS-1].vkey};
          end
          current_slot_next = widx;
        end
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      use_clock    <= '0;
      current_slot <= '0;
      last_key     <= '0;
      out_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      use_clock    <= use_clock_next;
      current_slot <= current_slot_next;
      last_key     <= last_key_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (load_out) begin
      out_q <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.slot_index   = out_q.slot_index;
  assign rsp.was_resident = out_q.was_resident;
  assign rsp.needs_clear  = out_q.needs_clear;
  assign rsp.evicted_key  = out_q.evicted_key;

  `LSPA_ASSERT_NOW(a_single_write, 1'b1, $onehot0(wr_en_vec), "more than one slot written")
  `LSPA_ASSERT_NOW(a_tail_in_scan, chain[NUM_SLOTS-1].valid, state == ST_SCAN, "probe outside scan")
  `LSPA_ASSERT_NOW(a_res_exclusive, rsp.valid, !(rsp.was_resident && rsp.needs_clear), "hit and clear")
  `LSPA_ASSERT_NEXT(a_clock_step, commit, use_clock == $past(use_clock) + 1'b1, "clock did not step")

endmodule
